// ===== hdl/uvsph_pkg.sv =====
// ---------------------------------------------------------------------------
// uvsph_pkg: shared types and constants of the UV sphere mesh generator
// Beat structs, result kinds, count limits and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package uvsph_pkg;

  localparam int CNT_W         = 9;   // width of counts and grid indices
  localparam int MAX_DIVISIONS = 256; // largest effective sector or stack count
  localparam int FRAC_BITS     = 14;  // fraction bits of the position outputs
  localparam int CORDIC_STEPS  = 16;
  localparam int ATAN_LEN      = 24;
  localparam int DIV_QW        = 34;  // quotient bits of n * 2^33 / d with n <= d
  localparam int DIV_CELLS     = DIV_QW - 1;
  localparam int CORNER_W      = 17;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  localparam logic signed [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
    32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
    32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
    32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
    32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
    32'sd1024,      32'sd512,       32'sd256,       32'sd128
  };

  typedef enum logic [0:0] {
    REG_SECTOR_COUNT = 1'b0,
    REG_STACK_COUNT  = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_ERROR    = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CNT_W-1:0] stack_index;
    logic [CNT_W-1:0] sector_index;
  } in_beat_t;

  typedef struct packed {
    kind_t                kind;
    logic signed [15:0]   pos_x;
    logic signed [15:0]   pos_y;
    logic signed [15:0]   pos_z;
    logic [15:0]          tex_s;
    logic [15:0]          tex_t;
    logic [CORNER_W-1:0]  corner_a;
    logic [CORNER_W-1:0]  corner_b;
    logic [CORNER_W-1:0]  corner_c;
    logic                 last;
  } out_beat_t;

  // Per-point bookkeeping that travels beside the arithmetic.
  typedef struct packed {
    logic                 err;
    logic                 tri_lo;
    logic                 tri_hi;
    logic [CORNER_W-1:0]  k1;
    logic [CORNER_W-1:0]  k2;
    logic [15:0]          tex_s;
    logic [15:0]          tex_t;
  } side_t;

  // Finished point handed to the output sequencer.
  typedef struct packed {
    side_t                side;
    logic signed [15:0]   pos_x;
    logic signed [15:0]   pos_y;
    logic signed [15:0]   pos_z;
  } point_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] r);
    logic [CNT_W-1:0] c;
    c = r;
    if (r == '0) begin
      c = CNT_W'(1);
    end else if (32'(r) > MAX_DIVISIONS) begin
      c = CNT_W'(MAX_DIVISIONS);
    end
    return c;
  endfunction

endpackage

// ===== hdl/uvsph_div_cell.sv =====
// ---------------------------------------------------------------------------
// uvsph_div_cell: one step of the long-division chain
// Doubles the partial remainder, subtracts the divisor when it fits and
// shifts the resulting quotient bit in; everything moves on each advance.
// ---------------------------------------------------------------------------
module uvsph_div_cell
  import uvsph_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [CNT_W-1:0]  d_i,
  input  logic [CNT_W-1:0]  rem_i,
  input  logic [DIV_QW-1:0] q_i,
  output logic [CNT_W-1:0]  d_o,
  output logic [CNT_W-1:0]  rem_o,
  output logic [DIV_QW-1:0] q_o
);

  logic [CNT_W:0]     dbl;
  logic               fits;
  logic [CNT_W-1:0]   d_r, rem_r, rem_nxt;
  logic [DIV_QW-1:0]  q_r, q_nxt;

  always_comb begin
    dbl     = {rem_i, 1'b0};
    fits    = dbl >= {1'b0, d_i};
    rem_nxt = fits ? CNT_W'(dbl - {1'b0, d_i}) : CNT_W'(dbl);
    q_nxt   = {q_i[DIV_QW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= d_i;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign d_o   = d_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;

endmodule

// ===== hdl/uvsph_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// uvsph_cordic_cell: one rotation step of the pipelined CORDIC
// Rotates (x, y) by the fixed angle of its step toward a zero residual
// angle and passes the quadrant along unchanged.
// ---------------------------------------------------------------------------
module uvsph_cordic_cell
  import uvsph_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  input  logic signed [32:0] z_i,
  input  logic [1:0]         quad_i,
  output logic signed [31:0] x_o,
  output logic signed [31:0] y_o,
  output logic signed [32:0] z_o,
  output logic [1:0]         quad_o
);

  logic signed [31:0] dx, dy, x_r, y_r, x_nxt, y_nxt;
  logic signed [32:0] z_r, z_nxt, ang;
  logic [1:0]         quad_r;

  always_comb begin
    dx  = y_i >>> STEP;
    dy  = x_i >>> STEP;
    ang = 33'(ATAN_Q30[STEP]);
    if (!z_i[32]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ang;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      quad_r <= quad_i;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign quad_o = quad_r;

endmodule

// ===== hdl/uvsph_out_seq.sv =====
// ---------------------------------------------------------------------------
// uvsph_out_seq: result sequencer
// Holds one finished point and sends its vertex (or error) beat and then
// up to two triangle beats, taking the next point as the last beat leaves.
// ---------------------------------------------------------------------------
module uvsph_out_seq
  import uvsph_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      ld,
  input  point_t    pt,
  output logic      ld_ok,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  point_t      pt_r;
  logic [2:0]  pend_r, pend_nxt;
  logic [2:0]  first;
  logic [2:0]  rest;

  always_comb begin
    first = pend_r & (~pend_r + 3'd1);
    rest  = pend_r & ~first;
  end

  assign out_valid = |pend_r;
  assign ld_ok     = (pend_r == '0) || (out_ready && (rest == '0));

  always_comb begin
    out_data      = '0;
    out_data.kind = KIND_VERTEX;
    out_data.last = (rest == '0);
    if (first[0]) begin
      if (pt_r.side.err) begin
        out_data.kind = KIND_ERROR;
      end else begin
        out_data.pos_x = pt_r.pos_x;
        out_data.pos_y = pt_r.pos_y;
        out_data.pos_z = pt_r.pos_z;
        out_data.tex_s = pt_r.side.tex_s;
        out_data.tex_t = pt_r.side.tex_t;
      end
    end else if (first[1]) begin
      out_data.kind     = KIND_TRIANGLE;
      out_data.corner_a = pt_r.side.k1;
      out_data.corner_b = pt_r.side.k2;
      out_data.corner_c = pt_r.side.k1 + CORNER_W'(1);
    end else begin
      out_data.kind     = KIND_TRIANGLE;
      out_data.corner_a = pt_r.side.k1 + CORNER_W'(1);
      out_data.corner_b = pt_r.side.k2;
      out_data.corner_c = pt_r.side.k2 + CORNER_W'(1);
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (out_valid && out_ready) begin
      pend_nxt = rest;
    end
    if (ld) begin
      pend_nxt = {pt.side.tri_hi & ~pt.side.err, pt.side.tri_lo & ~pt.side.err, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      pt_r <= pt;
    end
  end

endmodule

// ===== hdl/uv_sphere_mesh_generator.sv =====
// ---------------------------------------------------------------------------
// uv_sphere_mesh_generator: vertex and triangle records of a UV sphere
// A grid point goes through a 33-cell division chain, a phase multiplier,
// a pipelined CORDIC and a product stage, then leaves as 1 to 3 beats.
// ---------------------------------------------------------------------------
// One grid point (stack, sector) is taken per clock, so a point enters every
// cycle as long as results drain; it passes the entry, division, phase, radian,
// CORDIC and product registers and leaves as a vertex beat followed by up to
// two triangle beats, or one error beat for an index beyond the counts. The
// result port sends one beat per cycle while out_ready is high, so a stream of
// interior points is paced by that port. Counts of 0 act as 1 and counts above
// the maximum act as the maximum; write them only while the block is idle.
module uv_sphere_mesh_generator
  import uvsph_pkg::*;
#(
  parameter int CORDIC_STEPS_P = CORDIC_STEPS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        cfg_we,
  input  reg_idx_t    cfg_idx,
  input  logic [CNT_W-1:0] cfg_wdata
);

  localparam int ST_PH  = DIV_CELLS + 1;
  localparam int ST_MUL = DIV_CELLS + 3 + CORDIC_STEPS_P;
  localparam int NST    = ST_MUL + 1;
  localparam int SH_XY  = 60 - FRAC_BITS;
  localparam int SH_Z   = 30 - FRAC_BITS;
  localparam longint LIM = ((64'sd1 << FRAC_BITS) > 64'sd32767) ? 64'sd32767
                                                                 : (64'sd1 << FRAC_BITS);

  logic [CNT_W-1:0] sectors_r, stacks_r;
  logic             adv, ld_ok;
  logic             vld_r [NST];
  side_t            side_r [NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sectors_r <= CNT_W'(36);
      stacks_r  <= CNT_W'(18);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SECTOR_COUNT: sectors_r <= cfg_wdata;
        REG_STACK_COUNT:  stacks_r  <= cfg_wdata;
        default:          sectors_r <= sectors_r;
      endcase
    end
  end

  // The whole chain moves together; an empty tail lets it close up.
  assign adv      = ld_ok || !vld_r[NST-1];
  assign in_ready = adv;

  // Entry stage: counts, range checks, corner indices, first quotient bit.
  logic [CNT_W-1:0]    s_eff, t_eff, ii, jj;
  logic                lat_q0, lon_q0;
  logic [CNT_W-1:0]    lat_rem0, lon_rem0;
  logic [18:0]         row_base;
  side_t               ent_side;

  always_comb begin
    s_eff    = eff_count(sectors_r);
    t_eff    = eff_count(stacks_r);
    ii       = in_data.stack_index;
    jj       = in_data.sector_index;
    lat_q0   = ii >= t_eff;
    lon_q0   = jj >= s_eff;
    lat_rem0 = lat_q0 ? ii - t_eff : ii;
    lon_rem0 = lon_q0 ? jj - s_eff : jj;
    row_base = 19'(ii) * (19'(s_eff) + 19'd1);
    ent_side        = '0;
    ent_side.err    = (ii > t_eff) || (jj > s_eff);
    ent_side.tri_lo = (ii < t_eff) && (jj < s_eff) && (ii != '0);
    ent_side.tri_hi = (ii < t_eff) && (jj < s_eff) && (ii != t_eff - CNT_W'(1));
    ent_side.k1     = row_base[CORNER_W-1:0] + CORNER_W'(jj);
    ent_side.k2     = ent_side.k1 + CORNER_W'(s_eff) + CORNER_W'(1);
  end

  logic [CNT_W-1:0]  lat_d [DIV_CELLS+1];
  logic [CNT_W-1:0]  lat_rem [DIV_CELLS+1];
  logic [DIV_QW-1:0] lat_q [DIV_CELLS+1];
  logic [CNT_W-1:0]  lon_d [DIV_CELLS+1];
  logic [CNT_W-1:0]  lon_rem [DIV_CELLS+1];
  logic [DIV_QW-1:0] lon_q [DIV_CELLS+1];
  logic [CNT_W-1:0]  lat_d_r, lat_rem_r, lon_d_r, lon_rem_r;
  logic [DIV_QW-1:0] lat_q_r, lon_q_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      lat_d_r   <= t_eff;
      lat_rem_r <= lat_rem0;
      lat_q_r   <= DIV_QW'(lat_q0);
      lon_d_r   <= s_eff;
      lon_rem_r <= lon_rem0;
      lon_q_r   <= DIV_QW'(lon_q0);
    end
  end

  assign lat_d[0]   = lat_d_r;
  assign lat_rem[0] = lat_rem_r;
  assign lat_q[0]   = lat_q_r;
  assign lon_d[0]   = lon_d_r;
  assign lon_rem[0] = lon_rem_r;
  assign lon_q[0]   = lon_q_r;

  for (genvar c = 0; c < DIV_CELLS; c++) begin : g_div
    uvsph_div_cell u_lat (
      .clk(clk), .en(adv),
      .d_i(lat_d[c]), .rem_i(lat_rem[c]), .q_i(lat_q[c]),
      .d_o(lat_d[c+1]), .rem_o(lat_rem[c+1]), .q_o(lat_q[c+1])
    );
    uvsph_div_cell u_lon (
      .clk(clk), .en(adv),
      .d_i(lon_d[c]), .rem_i(lon_rem[c]), .q_i(lon_q[c]),
      .d_o(lon_d[c+1]), .rem_o(lon_rem[c+1]), .q_o(lon_q[c+1])
    );
  end

  // Phase stage. Quotients are floor(n * 2^33 / d); the rounded phases and
  // texture coordinates are all read from them.
  logic [DIV_QW-1:0] qlat, qlon;
  logic [DIV_QW:0]   lon_up;
  logic [DIV_QW-1:0] lat_up;
  logic [17:0]       ts_up, tt_up;
  logic [31:0]       plat_nxt, plon_nxt, plat_r, plon_r;
  side_t             ph_side;

  always_comb begin
    qlat     = lat_q[DIV_CELLS];
    qlon     = lon_q[DIV_CELLS];
    lon_up   = {1'b0, qlon} + (DIV_QW+1)'(1);
    plon_nxt = lon_up[32:1];
    lat_up   = {1'b0, qlat[DIV_QW-1:1]} + DIV_QW'(1);
    plat_nxt = 32'h4000_0000 - lat_up[32:1];
    ts_up    = {1'b0, qlon[DIV_QW-1:17]} + 18'd1;
    tt_up    = {1'b0, qlat[DIV_QW-1:17]} + 18'd1;
    ph_side       = side_r[ST_PH-1];
    ph_side.tex_s = ts_up[16:1];
    ph_side.tex_t = tt_up[16:1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      plat_r <= plat_nxt;
      plon_r <= plon_nxt;
    end
  end

  // Quarter-turn phase to radians in Q2.30.
  logic [60:0]        zlat_p, zlon_p;
  logic signed [32:0] zlat_r, zlon_r;
  logic [1:0]         qdlat_r, qdlon_r;

  always_comb begin
    zlat_p = 61'(plat_r[29:0]) * 61'(HALF_PI_Q30) + (61'd1 << 29);
    zlon_p = 61'(plon_r[29:0]) * 61'(HALF_PI_Q30) + (61'd1 << 29);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zlat_r  <= {2'b00, zlat_p[60:30]};
      zlon_r  <= {2'b00, zlon_p[60:30]};
      qdlat_r <= plat_r[31:30];
      qdlon_r <= plon_r[31:30];
    end
  end

  logic signed [31:0] xa [CORDIC_STEPS_P+1];
  logic signed [31:0] ya [CORDIC_STEPS_P+1];
  logic signed [32:0] za [CORDIC_STEPS_P+1];
  logic [1:0]         qa [CORDIC_STEPS_P+1];
  logic signed [31:0] xo [CORDIC_STEPS_P+1];
  logic signed [31:0] yo [CORDIC_STEPS_P+1];
  logic signed [32:0] zo [CORDIC_STEPS_P+1];
  logic [1:0]         qo [CORDIC_STEPS_P+1];

  assign xa[0] = CORDIC_GAIN_Q30;
  assign ya[0] = '0;
  assign za[0] = zlat_r;
  assign qa[0] = qdlat_r;
  assign xo[0] = CORDIC_GAIN_Q30;
  assign yo[0] = '0;
  assign zo[0] = zlon_r;
  assign qo[0] = qdlon_r;

  for (genvar k = 0; k < CORDIC_STEPS_P; k++) begin : g_cordic
    uvsph_cordic_cell #(.STEP(k)) u_lat (
      .clk(clk), .en(adv),
      .x_i(xa[k]), .y_i(ya[k]), .z_i(za[k]), .quad_i(qa[k]),
      .x_o(xa[k+1]), .y_o(ya[k+1]), .z_o(za[k+1]), .quad_o(qa[k+1])
    );
    uvsph_cordic_cell #(.STEP(k)) u_lon (
      .clk(clk), .en(adv),
      .x_i(xo[k]), .y_i(yo[k]), .z_i(zo[k]), .quad_i(qo[k]),
      .x_o(xo[k+1]), .y_o(yo[k+1]), .z_o(zo[k+1]), .quad_o(qo[k+1])
    );
  end

  // Quadrant fix-up and the two position products.
  logic signed [31:0] clat, slat, clon, slon, slat_r;
  logic signed [63:0] mx_r, my_r;

  always_comb begin
    case (qa[CORDIC_STEPS_P])
      2'd0:    begin clat = xa[CORDIC_STEPS_P];  slat = ya[CORDIC_STEPS_P];  end
      2'd1:    begin clat = -ya[CORDIC_STEPS_P]; slat = xa[CORDIC_STEPS_P];  end
      2'd2:    begin clat = -xa[CORDIC_STEPS_P]; slat = -ya[CORDIC_STEPS_P]; end
      default: begin clat = ya[CORDIC_STEPS_P];  slat = -xa[CORDIC_STEPS_P]; end
    endcase
    case (qo[CORDIC_STEPS_P])
      2'd0:    begin clon = xo[CORDIC_STEPS_P];  slon = yo[CORDIC_STEPS_P];  end
      2'd1:    begin clon = -yo[CORDIC_STEPS_P]; slon = xo[CORDIC_STEPS_P];  end
      2'd2:    begin clon = -xo[CORDIC_STEPS_P]; slon = -yo[CORDIC_STEPS_P]; end
      default: begin clon = yo[CORDIC_STEPS_P];  slon = -xo[CORDIC_STEPS_P]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx_r   <= clat * clon;
      my_r   <= clat * slon;
      slat_r <= slat;
    end
  end

  // Round to nearest (half up) and clamp to the unit range.
  logic signed [63:0] rx, ry, rz;
  point_t             pt;

  always_comb begin
    rx = (mx_r + (64'sd1 <<< (SH_XY - 1))) >>> SH_XY;
    ry = (my_r + (64'sd1 <<< (SH_XY - 1))) >>> SH_XY;
    rz = (64'(slat_r) + (64'sd1 <<< (SH_Z - 1))) >>> SH_Z;
    if (rx > LIM)       rx = LIM;
    else if (rx < -LIM) rx = -LIM;
    if (ry > LIM)       ry = LIM;
    else if (ry < -LIM) ry = -LIM;
    if (rz > LIM)       rz = LIM;
    else if (rz < -LIM) rz = -LIM;
    pt.side  = side_r[NST-1];
    pt.pos_x = rx[15:0];
    pt.pos_y = ry[15:0];
    pt.pos_z = rz[15:0];
  end

  // Valid bits and bookkeeping ride beside the datapath stages.
  for (genvar p = 0; p < NST; p++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[p] <= 1'b0;
      end else if (adv) begin
        vld_r[p] <= (p == 0) ? in_valid : vld_r[(p == 0) ? 0 : p-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (p == 0) begin
          side_r[p] <= ent_side;
        end else if (p == ST_PH) begin
          side_r[p] <= ph_side;
        end else begin
          side_r[p] <= side_r[(p == 0) ? 0 : p-1];
        end
      end
    end
  end

  uvsph_out_seq u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (adv && vld_r[NST-1]),
    .pt        (pt),
    .ld_ok     (ld_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== test/uv_sphere_mesh_generator_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uv_sphere_mesh_generator_test: self-checking bench of the sphere generator
// Grid points go in through a bursty sender; vertex, triangle and error beats
// are checked field by field against a bit-exact predictor of the block.
// ---------------------------------------------------------------------------
module uv_sphere_mesh_generator_test;
  import uvsph_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 120;

  typedef struct {
    int unsigned stack_i;
    int unsigned sector_j;
    bit          typed_err;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_beat_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_beat_t  out_data;
  logic       cfg_we = 1'b0;
  reg_idx_t   cfg_idx = REG_SECTOR_COUNT;
  logic [CNT_W-1:0] cfg_wdata = '0;

  out_beat_t  pending_beats[$];
  logic [CNT_W-1:0] sectors_reg = 9'd36;
  logic [CNT_W-1:0] stacks_reg  = 9'd18;
  int  errors = 0;
  int  points_sent = 0;
  int  beats_seen = 0;
  int  idle_cycles = 0;
  bit  hold_request = 1'b0;

  uv_sphere_mesh_generator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic longint unsigned clamp_count(input logic [CNT_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIVISIONS) return MAX_DIVISIONS;
    return r;
  endfunction

  // Appends one expected beat at the tail of the queue.
  function automatic void queue_beat(input out_beat_t b);
    pending_beats = {pending_beats, b};
  endfunction

  // Phase is 2^32 per turn; cos and sin come back in Q2.30.
  function automatic void phase_cos_sin(input logic [31:0] phase,
                                        output longint c, output longint s);
    longint unsigned rest;
    longint x, y, z, dx, dy;
    rest = phase[29:0];
    z = longint'((rest * HALF_PI_Q30 + (64'd1 << 29)) >> 30);
    x = CORDIC_GAIN_Q30;
    y = 0;
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q30[k];
      end else begin
        x += dx; y -= dy; z += ATAN_Q30[k];
      end
    end
    case (phase[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic signed [15:0] round_sat(input longint v, input int sh);
    longint r;
    r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic out_beat_t error_beat();
    out_beat_t b;
    b = '0;
    b.kind = KIND_ERROR;
    b.last = 1'b1;
    return b;
  endfunction

  task automatic predict_point(input int unsigned si, input int unsigned sj);
    longint unsigned nsec, nstk, i, j, qlat, qlon, k1, k2;
    longint clat, slat, clon, slon;
    out_beat_t b;
    nsec = clamp_count(sectors_reg);
    nstk = clamp_count(stacks_reg);
    i = si;
    j = sj;
    if (i > nstk || j > nsec) begin
      queue_beat(error_beat());
      return;
    end
    qlat = ((i << 32) + nstk) / (2 * nstk);
    qlon = ((j << 33) + nsec) / (2 * nsec);
    phase_cos_sin(32'(64'h4000_0000 - qlat), clat, slat);
    phase_cos_sin(32'(qlon), clon, slon);
    b = '0;
    b.kind  = KIND_VERTEX;
    b.pos_x = round_sat(clat * clon, 60 - FRAC_BITS);
    b.pos_y = round_sat(clat * slon, 60 - FRAC_BITS);
    b.pos_z = round_sat(slat, 30 - FRAC_BITS);
    b.tex_s = 16'((j * 65536 + nsec) / (2 * nsec));
    b.tex_t = 16'((i * 65536 + nstk) / (2 * nstk));
    b.last  = !(i < nstk && j < nsec && (i != 0 || i != nstk - 1));
    queue_beat(b);
    if (i < nstk && j < nsec) begin
      k1 = i * (nsec + 1) + j;
      k2 = k1 + nsec + 1;
      if (i != 0) begin
        b = '0;
        b.kind = KIND_TRIANGLE;
        b.corner_a = CORNER_W'(k1);
        b.corner_b = CORNER_W'(k2);
        b.corner_c = CORNER_W'(k1 + 1);
        b.last = (i == nstk - 1);
        queue_beat(b);
      end
      if (i != nstk - 1) begin
        b = '0;
        b.kind = KIND_TRIANGLE;
        b.corner_a = CORNER_W'(k1 + 1);
        b.corner_b = CORNER_W'(k2);
        b.corner_c = CORNER_W'(k2 + 1);
        b.last = 1'b1;
        queue_beat(b);
      end
    end
  endtask

  // Holds in_valid through the stall and predicts at the accepting edge.
  // The ready line only moves at rising edges, so it is read mid-cycle.
  task automatic send_point(input int unsigned si, input int unsigned sj, input bit typed);
    in_beat_t d;
    d.stack_index  = CNT_W'(si);
    d.sector_index = CNT_W'(sj);
    in_valid <= 1'b1;
    in_data  <= d;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (typed) queue_beat(error_beat());
    else predict_point(si, sj);
    points_sent++;
  endtask

  task automatic idle_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CNT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SECTOR_COUNT) sectors_reg = val;
    else stacks_reg = val;
    @(posedge clk);
  endtask

  // Receiver: ready follows one of four random patterns, drawn anew in turn; a hold
  // request keeps it low for a long stretch so the pipeline backs up into the input.
  initial begin
    int mode;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      for (int n = 0; n < 48; n++) begin
        @(posedge clk);
        if (hold_request) begin
          out_ready <= 1'b0;
          repeat (400) @(posedge clk);
          hold_request = 1'b0;
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", out_data.kind);
        errors++;
      end else begin
        e = pending_beats.pop_front();
        if (out_data.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_data.kind); errors++;
        end
        if (out_data.pos_x !== e.pos_x) begin
          $error("pos_x: expected %0d, got %0d", e.pos_x, out_data.pos_x); errors++;
        end
        if (out_data.pos_y !== e.pos_y) begin
          $error("pos_y: expected %0d, got %0d", e.pos_y, out_data.pos_y); errors++;
        end
        if (out_data.pos_z !== e.pos_z) begin
          $error("pos_z: expected %0d, got %0d", e.pos_z, out_data.pos_z); errors++;
        end
        if (out_data.tex_s !== e.tex_s) begin
          $error("tex_s: expected %0d, got %0d", e.tex_s, out_data.tex_s); errors++;
        end
        if (out_data.tex_t !== e.tex_t) begin
          $error("tex_t: expected %0d, got %0d", e.tex_t, out_data.tex_t); errors++;
        end
        if (out_data.corner_a !== e.corner_a) begin
          $error("corner_a: expected %0d, got %0d", e.corner_a, out_data.corner_a); errors++;
        end
        if (out_data.corner_b !== e.corner_b) begin
          $error("corner_b: expected %0d, got %0d", e.corner_b, out_data.corner_b); errors++;
        end
        if (out_data.corner_c !== e.corner_c) begin
          $error("corner_c: expected %0d, got %0d", e.corner_c, out_data.corner_c); errors++;
        end
        if (out_data.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_data.last); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    row_t directed[] = '{
      '{0, 0, 0}, '{18, 36, 0}, '{0, 36, 0}, '{18, 0, 0}, '{17, 35, 0},
      '{1, 1, 0}, '{9, 18, 0}, '{17, 0, 0}, '{0, 35, 0}, '{19, 0, 1},
      '{0, 37, 1}, '{511, 511, 1}, '{256, 0, 1}, '{0, 256, 1}, '{19, 37, 1}
    };
    int settings[][2] = '{
      '{0, 0}, '{1, 1}, '{256, 256}, '{300, 511}, '{7, 5},
      '{1, 2}, '{36, 18}, '{0, 256}
    };
    int unsigned nsec, nstk, si, sj, burst, per_phase;
    @(posedge clk);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[r]) begin
      send_point(directed[r].stack_i, directed[r].sector_j, directed[r].typed_err);
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 4));
    end
    drain_all();

    burst = 0;
    foreach (settings[p]) begin
      write_reg(REG_SECTOR_COUNT, CNT_W'(settings[p][0]));
      write_reg(REG_STACK_COUNT, CNT_W'(settings[p][1]));
      nsec = clamp_count(sectors_reg);
      nstk = clamp_count(stacks_reg);
      // The held phase offers more points than the pipeline can hold.
      per_phase = (p == 2) ? 90 : 46 + $urandom_range(0, 4);
      for (int n = 0; n < per_phase; n++) begin
        if (p == 2 && n == 0) hold_request = 1'b1;
        if (p == 4 && n == 25) drain_all();
        if ($urandom_range(0, 99) < 85) begin
          si = $urandom_range(0, nstk);
          sj = $urandom_range(0, nsec);
          if ($urandom_range(0, 9) == 0) si = ($urandom_range(0, 1) != 0) ? nstk : 0;
          if ($urandom_range(0, 9) == 0) sj = ($urandom_range(0, 1) != 0) ? nsec : 0;
        end else begin
          si = $urandom_range(0, 511);
          sj = $urandom_range(0, 511);
        end
        send_point(si, sj, 1'b0);
        if (burst == 0) begin
          burst = $urandom_range(1, 20);
          if ($urandom_range(0, 1) != 0) idle_gap($urandom_range(1, 12));
        end else begin
          burst--;
        end
      end
      drain_all();
    end

    $display("Covered %0d grid points and %0d result beats over %0d count settings,",
             points_sent, beats_seen, settings.size() + 1);
    $display("including zero, oversized and single-stack counts and out-of-range indices.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
